// File: rtl/lfcd_pkg.sv
// shared types, codes and functions for the link frame checker/decoder
// no dependencies; imported by every rtl module of the block
`timescale 1ns / 1ps

package lfcd_pkg;

  localparam int unsigned HdrLen   = 13;
  localparam int unsigned TrlLen   = 2;
  localparam int unsigned CntW     = 17;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CntW-1:0] CountMax = {CntW{1'b1}};
  localparam logic [CntW-1:0] MinLen   = CntW'(HdrLen + TrlLen);
  localparam logic [15:0]     CrcInit  = 16'hFFFF;
  localparam logic [15:0]     CrcPoly  = 16'h1021;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMagic   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgVersion = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLimit   = 2'd2;

  localparam logic [15:0] LimitReset = 16'd235;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StMagic    = 3'd2,
    StCrc      = 3'd3,
    StTooLong  = 3'd4,
    StLenMis   = 3'd5,
    StUnknown  = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic       we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  message_kind;
    logic [7:0]  version_seen;
    logic [7:0]  flag_bits;
    logic [31:0] correlation;
    logic [7:0]  sender_role;
    logic [7:0]  msg_class;
    logic [7:0]  service_code;
    logic [7:0]  op_code;
    logic [15:0] payload_bytes;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
  } kind_t;

  // one byte of crc-16/ccitt-false, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic kind_t kind_of(input logic [7:0] msg, input logic [7:0] svc,
                                    input logic [7:0] op);
    kind_t r;
    r = '{hit: 1'b1, kind: 5'd0};
    if (svc == 8'h09 && msg == 8'h04 && op == 8'h01) r.kind = 5'd0;
    else if (svc == 8'h01 && msg == 8'h01 && op == 8'h01) r.kind = 5'd1;
    else if (svc == 8'h01 && msg == 8'h02 && op == 8'h02) r.kind = 5'd2;
    else if (svc == 8'h01 && msg == 8'h01 && op == 8'h03) r.kind = 5'd3;
    else if (svc == 8'h01 && msg == 8'h02 && op == 8'h04) r.kind = 5'd4;
    else if (svc == 8'h01 && msg == 8'h01 && op == 8'h05) r.kind = 5'd6;
    else if (svc == 8'h01 && msg == 8'h02 && op == 8'h06) r.kind = 5'd7;
    else if (svc == 8'h01 && msg == 8'h03 && op == 8'h07) r.kind = 5'd5;
    else if (svc == 8'h08 && msg == 8'h01 && op == 8'h01) r.kind = 5'd8;
    else if (svc == 8'h08 && msg == 8'h02 && op == 8'h02) r.kind = 5'd9;
    else if (svc == 8'h08 && msg == 8'h02 && op == 8'h03) r.kind = 5'd10;
    else if (svc == 8'h07 && msg == 8'h01 && op == 8'h01) r.kind = 5'd11;
    else if (svc == 8'h07 && msg == 8'h01 && op == 8'h02) r.kind = 5'd12;
    else if (svc == 8'h07 && msg == 8'h01 && op == 8'h03) r.kind = 5'd13;
    else if (svc == 8'h07 && msg == 8'h02 && op == 8'h04) r.kind = 5'd14;
    else if (svc == 8'h06 && msg == 8'h04 && op == 8'h10) r.kind = 5'd17;
    else if (svc == 8'h06 && msg == 8'h04 && op == 8'h11) r.kind = 5'd18;
    else if (svc == 8'h06 && msg == 8'h04 && op == 8'h13) r.kind = 5'd20;
    else if (svc == 8'h06 && msg == 8'h05 && op == 8'h12) r.kind = 5'd19;
    else if (svc >= 8'h02 && svc <= 8'h06 && msg == 8'h01 &&
             (op == 8'h01 || op == 8'h03 || op == 8'h05)) r.kind = 5'd15;
    else if (svc >= 8'h02 && svc <= 8'h06 && (msg == 8'h02 || msg == 8'h03) &&
             (op == 8'h02 || op == 8'h04 || op == 8'h06)) r.kind = 5'd16;
    else r.hit = 1'b0;
    return r;
  endfunction

endpackage

// File: rtl/lfcd_if.sv
// valid/ready channel interfaces for frame bytes and decoded results
// depends on nothing but the payload widths of the block
`timescale 1ns / 1ps

interface lfcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       final_byte;

  modport source (output valid, output frame_byte, output final_byte, input ready);
  modport sink   (input valid, input frame_byte, input final_byte, output ready);
endinterface

interface lfcd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [4:0]  message_kind;
  logic [7:0]  version_seen;
  logic [7:0]  flag_bits;
  logic [31:0] correlation;
  logic [7:0]  sender_role;
  logic [7:0]  msg_class;
  logic [7:0]  service_code;
  logic [7:0]  op_code;
  logic [15:0] payload_bytes;

  modport source (output valid, output status, output message_kind, output version_seen,
                  output flag_bits, output correlation, output sender_role,
                  output msg_class, output service_code, output op_code,
                  output payload_bytes, input ready);
  modport sink   (input valid, input status, input message_kind, input version_seen,
                  input flag_bits, input correlation, input sender_role,
                  input msg_class, input service_code, input op_code,
                  input payload_bytes, output ready);
endinterface

// File: rtl/lfcd_in_reg.sv
// input register stage: holds one frame byte until the core takes it
// depends on lfcd_pkg
`timescale 1ns / 1ps

module lfcd_in_reg import lfcd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_item_t item_i,
  output logic     valid_o,
  input  logic     take_i,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/lfcd_core.sv
// frame state (count, crc, trailer delay, header) and the end-of-frame checks
// depends on lfcd_pkg for crc_feed, kind_of and the result type
`timescale 1ns / 1ps

module lfcd_core import lfcd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_wr_t  cfg_i,
  input  logic     valid_i,
  input  in_item_t item_i,
  output logic     take_o,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output result_t  res_o
);

  logic [7:0]      magic_q, version_q;
  logic [15:0]     limit_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      dly0_q, dly1_q;
  logic [7:0]      hdr_q [HdrLen];
  logic            last;
  logic [15:0]     rx_crc, plen;
  kind_t           kind;
  result_t         res;

  assign last        = item_i.final_byte;
  assign take_o      = valid_i && (!last || res_ready_i);
  assign res_valid_o = valid_i && last;

  assign cnt_d  = (cnt_q != CountMax) ? cnt_q + CntW'(1) : cnt_q;
  assign crc_d  = (cnt_q >= CntW'(2)) ? crc_feed(crc_q, dly1_q) : crc_q;
  assign rx_crc = {item_i.frame_byte, dly0_q};
  assign plen   = {hdr_q[12], hdr_q[11]};
  assign kind   = kind_of(hdr_q[2], hdr_q[9], hdr_q[10]);

  always_comb begin
    res = '0;
    if (cnt_d < MinLen) begin
      res.status = StShort;
    end else if (hdr_q[0] != magic_q || hdr_q[1] != version_q) begin
      res.status = StMagic;
    end else if (rx_crc != crc_d) begin
      res.status = StCrc;
    end else if (plen > limit_q) begin
      res.status = StTooLong;
    end else if (cnt_d != MinLen + CntW'(plen)) begin
      res.status = StLenMis;
    end else if (!kind.hit) begin
      res.status = StUnknown;
    end else begin
      res.status        = StOk;
      res.message_kind  = kind.kind;
      res.version_seen  = hdr_q[1];
      res.flag_bits     = hdr_q[3];
      res.correlation   = {hdr_q[7], hdr_q[6], hdr_q[5], hdr_q[4]};
      res.sender_role   = hdr_q[8];
      res.msg_class     = hdr_q[2];
      res.service_code  = hdr_q[9];
      res.op_code       = hdr_q[10];
      res.payload_bytes = plen;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      version_q <= '0;
      limit_q   <= LimitReset;
      cnt_q     <= '0;
      crc_q     <= CrcInit;
      dly0_q    <= '0;
      dly1_q    <= '0;
    end else begin
      if (cfg_i.we) begin
        case (cfg_i.idx)
          CfgMagic:   magic_q   <= cfg_i.data[7:0];
          CfgVersion: version_q <= cfg_i.data[7:0];
          CfgLimit:   limit_q   <= cfg_i.data;
          default:    ;
        endcase
      end
      if (take_o) begin
        if (last) begin
          // frame done, back to the start-of-frame state
          cnt_q  <= '0;
          crc_q  <= CrcInit;
          dly0_q <= '0;
          dly1_q <= '0;
        end else begin
          cnt_q  <= cnt_d;
          crc_q  <= crc_d;
          dly0_q <= item_i.frame_byte;
          dly1_q <= dly0_q;
        end
      end
    end
  end

  // header bytes land at their frame position
  always_ff @(posedge clk_i) begin
    if (take_o && cnt_q < CntW'(HdrLen)) begin
      hdr_q[cnt_q[3:0]] <= item_i.frame_byte;
    end
  end

endmodule

// File: rtl/lfcd_out_reg.sv
// result register: holds one decoded result until the receiver takes it
// depends on lfcd_pkg
`timescale 1ns / 1ps

module lfcd_out_reg import lfcd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  result_t res_i,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;
  logic    load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : ((valid_q && ready_i) ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: rtl/link_frame_checker_decoder.sv
// Link frame checker/decoder, top level.
// Frame bytes come in on in_i, one byte per item, final_byte set on the last
// byte of a frame. The block counts bytes, keeps the 13 header bytes, runs
// CRC-16/CCITT-FALSE over all but the two trailer bytes and, on the final
// byte, puts one result on out_o: a status code and the decoded header
// fields (all zero when the status is not ok). Non-final bytes give nothing.
// Configuration (magic, version, payload limit) is written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write it only while the
// block is idle, as the block itself does not enforce this. Throughput:
// one byte per cycle, save that a final byte waits while the result
// register is full; the per-byte CRC step and the frame checks are
// combinational between the input register and the result register.
// When out_o is stalled with a result held, the next non-final bytes still
// flow in; the next final byte waits in the input register until the
// result register frees up.
// Reset puts count, CRC, trailer delay, valid flags and config at defaults.
// depends on lfcd_pkg, lfcd_if, lfcd_in_reg, lfcd_core, lfcd_out_reg
`timescale 1ns / 1ps

module link_frame_checker_decoder import lfcd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  lfcd_in_if.sink             in_i,
  lfcd_out_if.source          out_o
);

  cfg_wr_t  cfg;
  in_item_t in_item, st_item;
  logic     st_valid, st_take;
  logic     res_valid, res_ready;
  result_t  res, out_res;

  assign cfg     = '{we: cfg_we_i, idx: cfg_idx_i, data: cfg_data_i};
  assign in_item = '{frame_byte: in_i.frame_byte, final_byte: in_i.final_byte};

  lfcd_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .item_i  (in_item),
    .valid_o (st_valid),
    .take_i  (st_take),
    .item_o  (st_item)
  );

  lfcd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (st_valid),
    .item_i      (st_item),
    .take_o      (st_take),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  lfcd_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (res_valid),
    .ready_o (res_ready),
    .res_i   (res),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (out_res)
  );

  assign out_o.status        = out_res.status;
  assign out_o.message_kind  = out_res.message_kind;
  assign out_o.version_seen  = out_res.version_seen;
  assign out_o.flag_bits     = out_res.flag_bits;
  assign out_o.correlation   = out_res.correlation;
  assign out_o.sender_role   = out_res.sender_role;
  assign out_o.msg_class     = out_res.msg_class;
  assign out_o.service_code  = out_res.service_code;
  assign out_o.op_code       = out_res.op_code;
  assign out_o.payload_bytes = out_res.payload_bytes;

endmodule
